// ----- rtl/rsd_pkg.sv -----
// Package for ray_segment_distance: shared widths, beat payload types and
// the per-cell state records. No dependencies.
package rsd_pkg;

  localparam int COORD_W = 16;
  localparam int RAD_W   = 32;   // dx^2 + dy^2
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int NUM_W   = 34;   // |num|
  localparam int DEN_W   = 33;   // |den|
  localparam int PROD_W  = ROOT_W + NUM_W;
  localparam int Q_W     = 24;   // distance width
  localparam int DSH_W   = DEN_W + Q_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] seg_ax;
    logic signed [COORD_W-1:0] seg_ay;
    logic signed [COORD_W-1:0] seg_bx;
    logic signed [COORD_W-1:0] seg_by;
  } in_beat_t;

  // Data riding along the square-root chain
  typedef struct packed {
    logic             miss;
    logic             neg;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
  } sq_pay_t;

  // Square-root cell state
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_st_t;

  // Divider cell state
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [DSH_W-1:0]  dsh;
    logic [Q_W-1:0]    quo;
    logic              miss;
    logic              neg;
    logic              ovf;
  } dv_st_t;

  // Pipeline control handed to each cell
  typedef struct packed {
    logic adv;
    logic vld;
  } cell_ctl_t;

endpackage

// ----- rtl/rsd_in_if.sv -----
// Input channel of ray_segment_distance: valid/ready plus the ray and segment.
// Depends on rsd_pkg.
interface rsd_in_if;
  logic valid;
  logic ready;
  logic signed [rsd_pkg::COORD_W-1:0] origin_x;
  logic signed [rsd_pkg::COORD_W-1:0] origin_y;
  logic signed [rsd_pkg::COORD_W-1:0] dir_x;
  logic signed [rsd_pkg::COORD_W-1:0] dir_y;
  logic signed [rsd_pkg::COORD_W-1:0] seg_ax;
  logic signed [rsd_pkg::COORD_W-1:0] seg_ay;
  logic signed [rsd_pkg::COORD_W-1:0] seg_bx;
  logic signed [rsd_pkg::COORD_W-1:0] seg_by;
  modport source (output valid, origin_x, origin_y, dir_x, dir_y,
                  seg_ax, seg_ay, seg_bx, seg_by, input ready);
  modport sink   (input valid, origin_x, origin_y, dir_x, dir_y,
                  seg_ax, seg_ay, seg_bx, seg_by, output ready);
endinterface

// ----- rtl/rsd_out_if.sv -----
// Result channel of ray_segment_distance: valid/ready, hit and distance.
// Depends on rsd_pkg.
interface rsd_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [rsd_pkg::Q_W-1:0] distance;
  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

// ----- rtl/rsd_front.sv -----
// Front end: offsets, cross products, line terms, sign test and radicand.
// Two register stages. Depends on rsd_pkg.
module rsd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                vld_i,
  input  rsd_pkg::in_beat_t   beat_i,
  input  logic [15:0]         margin,
  output logic                vld_o,
  output rsd_pkg::sq_pay_t    pay_o,
  output logic [rsd_pkg::RAD_W-1:0] rad_o
);

  logic signed [16:0] oax, oay, obx, oby, la, lb;
  logic signed [32:0] p_ca1, p_ca2, p_cb1, p_cb2, p_d1, p_d2;
  logic signed [33:0] p_n1, p_n2;
  logic signed [31:0] p_xx, p_yy;

  logic signed [32:0] ca1_r, ca2_r, cb1_r, cb2_r, d1_r, d2_r;
  logic signed [33:0] n1_r, n2_r;
  logic        [30:0] xx_r, yy_r;
  logic               v1_r;

  // stage 1: offsets and products
  always_comb begin
    oax   = 17'(beat_i.seg_ax) - 17'(beat_i.origin_x);
    oay   = 17'(beat_i.seg_ay) - 17'(beat_i.origin_y);
    obx   = 17'(beat_i.seg_bx) - 17'(beat_i.origin_x);
    oby   = 17'(beat_i.seg_by) - 17'(beat_i.origin_y);
    la    = 17'(beat_i.seg_ay) - 17'(beat_i.seg_by);
    lb    = 17'(beat_i.seg_bx) - 17'(beat_i.seg_ax);
    p_ca1 = 33'(oax) * 33'(beat_i.dir_y);
    p_ca2 = 33'(oay) * 33'(beat_i.dir_x);
    p_cb1 = 33'(obx) * 33'(beat_i.dir_y);
    p_cb2 = 33'(oby) * 33'(beat_i.dir_x);
    p_d1  = 33'(la) * 33'(beat_i.dir_x);
    p_d2  = 33'(lb) * 33'(beat_i.dir_y);
    p_n1  = 34'(la) * 34'(oax);
    p_n2  = 34'(lb) * 34'(oay);
    p_xx  = 32'(beat_i.dir_x) * 32'(beat_i.dir_x);
    p_yy  = 32'(beat_i.dir_y) * 32'(beat_i.dir_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ca1_r <= p_ca1;
      ca2_r <= p_ca2;
      cb1_r <= p_cb1;
      cb2_r <= p_cb2;
      d1_r  <= p_d1;
      d2_r  <= p_d2;
      n1_r  <= p_n1;
      n2_r  <= p_n2;
      xx_r  <= p_xx[30:0];
      yy_r  <= p_yy[30:0];
    end
  end

  // stage 2: sums, sign test, magnitudes
  logic signed [34:0] ca, cb, m_pos, m_neg, num;
  logic signed [33:0] den;
  logic               same_sign;
  rsd_pkg::sq_pay_t   pay_nxt;

  always_comb begin
    ca        = 35'(ca1_r) - 35'(ca2_r);
    cb        = 35'(cb1_r) - 35'(cb2_r);
    num       = 35'(n1_r) + 35'(n2_r);
    den       = 34'(d1_r) + 34'(d2_r);
    m_pos     = $signed({19'b0, margin});
    m_neg     = -m_pos;
    same_sign = ((ca > m_pos) && (cb > m_pos)) || ((ca < m_neg) && (cb < m_neg));
    pay_nxt.miss    = same_sign || (den == '0);
    pay_nxt.neg     = (num != '0) && (num[34] != den[33]);
    pay_nxt.num_mag = num[34] ? rsd_pkg::NUM_W'(-num) : rsd_pkg::NUM_W'(num);
    pay_nxt.den_mag = den[33] ? rsd_pkg::DEN_W'(-den) : rsd_pkg::DEN_W'(den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay_o <= pay_nxt;
      rad_o <= 32'(xx_r) + 32'(yy_r);
    end
  end

endmodule

// ----- rtl/rsd_sqrt_cell.sv -----
// One digit of the integer square root: two radicand bits per cell.
// Depends on rsd_pkg.
module rsd_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rsd_pkg::cell_ctl_t ctl_i,
  input  rsd_pkg::sq_st_t   st_i,
  input  rsd_pkg::sq_pay_t  pay_i,
  output logic              vld_o,
  output rsd_pkg::sq_st_t   st_o,
  output rsd_pkg::sq_pay_t  pay_o
);

  logic [rsd_pkg::REM_W-1:0] rem2, trial;
  rsd_pkg::sq_st_t st_nxt;

  // trial subtract of (root << 2) | 1
  always_comb begin
    rem2  = {st_i.rem[rsd_pkg::REM_W-3:0], st_i.rad[rsd_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, st_i.root, 2'b01};
    st_nxt.rad = {st_i.rad[rsd_pkg::RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      st_nxt.rem  = rem2 - trial;
      st_nxt.root = {st_i.root[rsd_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      st_nxt.rem  = rem2;
      st_nxt.root = {st_i.root[rsd_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_o <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      st_o  <= st_nxt;
      pay_o <= pay_i;
    end
  end

endmodule

// ----- rtl/rsd_div_cell.sv -----
// One quotient bit of the restoring divider; divisor shifts right per cell.
// Depends on rsd_pkg.
module rsd_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rsd_pkg::cell_ctl_t ctl_i,
  input  rsd_pkg::dv_st_t    st_i,
  output logic               vld_o,
  output rsd_pkg::dv_st_t    st_o
);

  rsd_pkg::dv_st_t st_nxt;

  // compare remainder with shifted divisor
  always_comb begin
    st_nxt     = st_i;
    st_nxt.dsh = {1'b0, st_i.dsh[rsd_pkg::DSH_W-1:1]};
    if (rsd_pkg::DSH_W'(st_i.rem) >= st_i.dsh) begin
      st_nxt.rem = st_i.rem - st_i.dsh[rsd_pkg::PROD_W-1:0];
      st_nxt.quo = {st_i.quo[rsd_pkg::Q_W-2:0], 1'b1};
    end else begin
      st_nxt.quo = {st_i.quo[rsd_pkg::Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_o <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      st_o <= st_nxt;
    end
  end

endmodule

// ----- rtl/ray_segment_distance.sv -----
// Top level of the 2D ray against segment distance unit.
// Depends on rsd_pkg, rsd_in_if, rsd_out_if, rsd_front, rsd_sqrt_cell, rsd_div_cell.
//
// Usage:
//  - in_ch (valid/ready) carries one ray and one segment per beat, signed Q8.8.
//  - out_ch (valid/ready) returns one beat per input: hit and an unsigned
//    Q16.8 distance, saturated; a miss gives hit 0 and distance 0.
//  - cfg_we/cfg_wdata write sign_margin; write it only while the block is idle.
//  - Throughput: one beat per cycle while out_ch keeps taking results. Path
//    from acceptance to out_ch.valid: 2 front stages, 16 square-root cells,
//    1 multiply stage, 1 range stage, 24 divider cells, 1 output register.
//  - The whole pipeline moves as one: when out_ch holds a beat that is not
//    taken, every stage holds and in_ch.ready drops; the output register
//    lets a new beat enter while the finished one is being taken.
//  - Reset (rst_n low, synchronous) clears every stage valid and sets
//    sign_margin to 0; beats still in flight are dropped and none are produced.
module ray_segment_distance (
  input  logic        clk,
  input  logic        rst_n,
  rsd_in_if.sink      in_ch,
  rsd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int SQ_N = rsd_pkg::ROOT_W;
  localparam int DV_N = rsd_pkg::Q_W;

  logic        adv;
  logic [15:0] margin_r;
  logic        out_valid_r;
  logic        out_hit_r;
  logic [rsd_pkg::Q_W-1:0] out_dist_r;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;
  assign out_ch.distance = out_dist_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else if (cfg_we) begin
      margin_r <= cfg_wdata;
    end
  end

  // front end
  rsd_pkg::in_beat_t beat;
  logic              f_vld;
  rsd_pkg::sq_pay_t  f_pay;
  logic [rsd_pkg::RAD_W-1:0] f_rad;

  always_comb begin
    beat.origin_x = in_ch.origin_x;
    beat.origin_y = in_ch.origin_y;
    beat.dir_x    = in_ch.dir_x;
    beat.dir_y    = in_ch.dir_y;
    beat.seg_ax   = in_ch.seg_ax;
    beat.seg_ay   = in_ch.seg_ay;
    beat.seg_bx   = in_ch.seg_bx;
    beat.seg_by   = in_ch.seg_by;
  end

  rsd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (in_ch.valid),
    .beat_i (beat),
    .margin (margin_r),
    .vld_o  (f_vld),
    .pay_o  (f_pay),
    .rad_o  (f_rad)
  );

  // square-root chain
  logic               sq_vld [SQ_N+1];
  rsd_pkg::sq_st_t    sq_st  [SQ_N+1];
  rsd_pkg::sq_pay_t   sq_pay [SQ_N+1];

  assign sq_vld[0]      = f_vld;
  assign sq_st[0].rad   = f_rad;
  assign sq_st[0].rem   = '0;
  assign sq_st[0].root  = '0;
  assign sq_pay[0]      = f_pay;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    rsd_pkg::cell_ctl_t ctl;
    assign ctl.adv = adv;
    assign ctl.vld = sq_vld[i];
    rsd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl),
      .st_i  (sq_st[i]),
      .pay_i (sq_pay[i]),
      .vld_o (sq_vld[i+1]),
      .st_o  (sq_st[i+1]),
      .pay_o (sq_pay[i+1])
    );
  end

  // length times |num|
  logic                      m_vld_r;
  logic [rsd_pkg::PROD_W-1:0] m_prod_r;
  logic [rsd_pkg::DEN_W-1:0]  m_den_r;
  logic                      m_miss_r, m_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= sq_vld[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_prod_r <= rsd_pkg::PROD_W'(sq_st[SQ_N].root) *
                  rsd_pkg::PROD_W'(sq_pay[SQ_N].num_mag);
      m_den_r  <= sq_pay[SQ_N].den_mag;
      m_miss_r <= sq_pay[SQ_N].miss;
      m_neg_r  <= sq_pay[SQ_N].neg;
    end
  end

  // range check: quotient at or above 2^24 saturates
  logic            dv_vld [DV_N+1];
  rsd_pkg::dv_st_t dv_st  [DV_N+1];
  rsd_pkg::dv_st_t r_nxt;
  logic            r_vld_r;
  rsd_pkg::dv_st_t r_st_r;

  always_comb begin
    r_nxt.rem  = m_prod_r;
    r_nxt.dsh  = {1'b0, m_den_r, {(rsd_pkg::Q_W-1){1'b0}}};
    r_nxt.quo  = '0;
    r_nxt.miss = m_miss_r;
    r_nxt.neg  = m_neg_r;
    r_nxt.ovf  = rsd_pkg::DSH_W'(m_prod_r) >= {m_den_r, {rsd_pkg::Q_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (adv) begin
      r_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_st_r <= r_nxt;
    end
  end

  // divider chain
  assign dv_vld[0] = r_vld_r;
  assign dv_st[0]  = r_st_r;

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    rsd_pkg::cell_ctl_t ctl;
    assign ctl.adv = adv;
    assign ctl.vld = dv_vld[j];
    rsd_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl),
      .st_i  (dv_st[j]),
      .vld_o (dv_vld[j+1]),
      .st_o  (dv_st[j+1])
    );
  end

  // final decision and output register
  logic [rsd_pkg::Q_W-1:0] q_sat;
  logic                    hit_nxt;
  logic [rsd_pkg::Q_W-1:0] dist_nxt;

  always_comb begin
    q_sat = dv_st[DV_N].ovf ? '1 : dv_st[DV_N].quo;
    if (dv_st[DV_N].miss) begin
      hit_nxt  = 1'b0;
      dist_nxt = '0;
    end else if (dv_st[DV_N].neg) begin
      hit_nxt  = (q_sat <= rsd_pkg::Q_W'(margin_r));
      dist_nxt = '0;
    end else begin
      hit_nxt  = 1'b1;
      dist_nxt = q_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r  <= hit_nxt;
      out_dist_r <= dist_nxt;
    end
  end

endmodule

// ----- bench/rsd_tb_pkg.sv -----
// Bench-side types for the ray/segment distance testbench: the expected
// result record and a directed-stimulus row. Depends on rsd_pkg.
package rsd_tb_pkg;
  import rsd_pkg::*;

  typedef struct packed {
    logic          hit;
    logic [Q_W-1:0] distance;
  } hit_dist_t;

  // Directed row: optional margin write, the beat, optional typed-in result
  typedef struct {
    bit             set_margin;
    logic [15:0]    margin;
    in_beat_t       beat;
    bit             fixed;
    hit_dist_t      result;
  } ray_row_t;
endpackage

// ----- bench/tb_ray_segment_distance.sv -----
// Self-checking bench for ray_segment_distance: directed table then random
// rays and segments, checked against an exact integer predictor.
// Depends on rsd_pkg, rsd_tb_pkg, rsd_in_if, rsd_out_if and the RTL.
module tb_ray_segment_distance;
  timeunit 1ns;
  timeprecision 1ps;
  import rsd_pkg::*;
  import rsd_tb_pkg::*;

  localparam int LATENCY   = 45;
  localparam int N_RANDOM  = 1200;
  localparam int STALL_CAP = 4000;
  localparam logic [23:0] DIST_SAT = 24'hFFFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  rsd_in_if  in_ch ();
  rsd_out_if out_ch ();

  ray_segment_distance uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  logic [15:0] margin_now;
  hit_dist_t   pending_hits[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic int sign_of(input longint v, input logic [15:0] m);
    longint lim;
    lim = longint'(m);
    if (v < -lim) return -1;
    return (v > lim) ? 1 : 0;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned s);
    longint unsigned r, lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= s) lo = mid;
      else hi = mid;
    end
    r = lo;
    return r;
  endfunction

  // Exact distance along the ray, with miss/behind/saturation rules
  function automatic hit_dist_t ray_hit_distance(input in_beat_t b, input logic [15:0] m);
    hit_dist_t res;
    longint oax, oay, obx, oby, ca, cb, la, lb, num, den;
    longint unsigned len, q, nm, dm;
    bit neg;
    res = '0;
    oax = longint'(b.seg_ax) - longint'(b.origin_x);
    oay = longint'(b.seg_ay) - longint'(b.origin_y);
    obx = longint'(b.seg_bx) - longint'(b.origin_x);
    oby = longint'(b.seg_by) - longint'(b.origin_y);
    ca = oax * longint'(b.dir_y) - oay * longint'(b.dir_x);
    cb = obx * longint'(b.dir_y) - oby * longint'(b.dir_x);
    if (sign_of(ca, m) * sign_of(cb, m) > 0) return res;
    la = -(longint'(b.seg_by) - longint'(b.seg_ay));
    lb = longint'(b.seg_bx) - longint'(b.seg_ax);
    num = la * oax + lb * oay;
    den = la * longint'(b.dir_x) + lb * longint'(b.dir_y);
    if (den == 0) return res;
    len = floor_sqrt(longint'(b.dir_x) * longint'(b.dir_x)
                     + longint'(b.dir_y) * longint'(b.dir_y));
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q = (len * nm) / dm;
    neg = (num != 0) && ((num < 0) != (den < 0));
    if (neg) begin
      if (q > longint'(m)) return res;
      q = 0;
    end
    if (q > DIST_SAT) q = DIST_SAT;
    res.hit = 1'b1;
    res.distance = q[23:0];
    return res;
  endfunction

  function automatic in_beat_t mk(input int ox, oy, dx, dy, ax, ay, bx, by);
    in_beat_t b;
    b.origin_x = 16'(ox); b.origin_y = 16'(oy); b.dir_x = 16'(dx); b.dir_y = 16'(dy);
    b.seg_ax = 16'(ax); b.seg_ay = 16'(ay); b.seg_bx = 16'(bx); b.seg_by = 16'(by);
    return b;
  endfunction

  // Mostly well-formed hits: segment straddles the ray, small coordinates
  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int mode, span, t;
    mode = $urandom_range(0, 9);
    span = (mode < 2) ? 32767 : (mode < 5 ? 2047 : 255);
    b.origin_x = 16'($urandom_range(0, 2 * span) - span);
    b.origin_y = 16'($urandom_range(0, 2 * span) - span);
    b.dir_x = 16'($urandom_range(0, 2 * span) - span);
    b.dir_y = 16'($urandom_range(0, 2 * span) - span);
    if (mode == 0) begin
      b.origin_x = 16'($urandom); b.origin_y = 16'($urandom); b.dir_x = 16'($urandom);
      b.dir_y = 16'($urandom); b.seg_ax = 16'($urandom); b.seg_ay = 16'($urandom);
      b.seg_bx = 16'($urandom); b.seg_by = 16'($urandom);
    end else begin
      t = $urandom_range(0, 8);
      // point at or ahead of the origin along the ray, then a segment through it
      b.seg_ax = 16'(b.origin_x + ((int'(b.dir_x) * t) >>> 2) + $urandom_range(0, 64) - 32);
      b.seg_ay = 16'(b.origin_y + ((int'(b.dir_y) * t) >>> 2) + $urandom_range(0, 64) - 32);
      b.seg_bx = 16'(2 * (b.origin_x + ((int'(b.dir_x) * t) >>> 2)) - b.seg_ax);
      b.seg_by = 16'(2 * (b.origin_y + ((int'(b.dir_y) * t) >>> 2)) - b.seg_ay);
      if (mode == 9) begin b.dir_x = 16'd0; b.dir_y = 16'd0; end
    end
    return b;
  endfunction

  // valid stays high after a beat unless a gap follows
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.origin_x, in_ch.origin_y, in_ch.dir_x, in_ch.dir_y,
     in_ch.seg_ax, in_ch.seg_ay, in_ch.seg_bx, in_ch.seg_by} <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_hits.push_back(ray_hit_distance(b, margin_now));
  endtask

  task automatic write_margin(input logic [15:0] m);
    in_ch.valid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    margin_now = m;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.dir_x, in_ch.dir_y,
     in_ch.seg_ax, in_ch.seg_ay, in_ch.seg_bx, in_ch.seg_by} = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls plus one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    hit_dist_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_hits.pop_front();
        if (out_ch.hit !== want.hit)
          report_mismatch($sformatf("hit %b want %b", out_ch.hit, want.hit));
        if (out_ch.distance !== want.distance)
          report_mismatch($sformatf("distance %h want %h", out_ch.distance,
                                    want.distance));
      end
    end
  end

  // Watchdog on cycles without any accepted beat or margin write
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles > STALL_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    ray_row_t rows[$];
    ray_row_t r;
    logic [15:0] margins[5];
    margin_now = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    r = '{0, 16'd0, mk(0, 0, 256, 0, 512, -256, 512, 256), 1, '{1'b1, 24'd512}};
    rows.push_back(r);
    r = '{0, 16'd0, mk(0, 0, 0, 0, 512, -256, 512, 256), 1, '{1'b0, 24'd0}};
    rows.push_back(r);
    r = '{0, 16'd0, mk(0, 0, 256, 0, -512, -256, -512, 256), 1, '{1'b0, 24'd0}};
    rows.push_back(r);
    r = '{0, 16'd0, mk(0, 0, 256, 0, 512, 256, 512, 512), 1, '{1'b0, 24'd0}};
    rows.push_back(r);
    r = '{0, 16'd0, mk(0, 0, 256, 0, 512, 0, 512, 0), 1, '{1'b0, 24'd0}};
    rows.push_back(r);
    r = '{0, 16'd0, mk(0, 0, 256, 0, 512, 0, 512, 256), 0, '0};
    rows.push_back(r);
    r = '{0, 16'd0, mk(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767),
          0, '0};
    rows.push_back(r);
    r = '{0, 16'd0, mk(-32768, 0, 32767, 0, 32767, -32768, 32767, 32767), 0, '0};
    rows.push_back(r);
    r = '{0, 16'd0, mk(-32768, 0, 1, 0, 32767, -1, 32767, 1), 0, '0};
    rows.push_back(r);
    r = '{0, 16'd0, mk(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768),
          0, '0};
    rows.push_back(r);
    r = '{1, 16'hFFFF, mk(0, 0, 256, 0, -1, -256, -1, 256), 1, '{1'b1, 24'd0}};
    rows.push_back(r);
    r = '{0, 16'hFFFF, mk(0, 0, 256, 0, 512, 256, 512, 512), 0, '0};
    rows.push_back(r);
    r = '{1, 16'd4, mk(0, 0, 256, 0, -2, -256, -2, 256), 0, '0};
    rows.push_back(r);
    r = '{0, 16'd4, mk(0, 0, 256, 0, 512, 0, 512, 256), 0, '0};
    rows.push_back(r);
    r = '{1, 16'd0, mk(0, 0, -256, 0, 512, -256, 512, 256), 1, '{1'b0, 24'd0}};
    rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].set_margin) write_margin(rows[i].margin);
      send_beat(rows[i].beat);
      if (rows[i].fixed) begin
        pending_hits.pop_back();
        pending_hits.push_back(rows[i].result);
      end
    end

    // Random phases at several margins; a long result stall in the first
    margins = '{16'd0, 16'd1, 16'd255, 16'h8000, 16'hFFFF};
    hold_off = 1'b1;
    foreach (margins[p]) begin
      write_margin(margins[p]);
      repeat (N_RANDOM / 5) send_beat(rand_beat());
    end

    in_ch.valid <= 1'b0;
    fork
      wait (pending_hits.size() == 0);
      begin
        repeat (200000) @(posedge clk);
        report_mismatch("results still outstanding");
      end
    join_any
    disable fork;
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/rsd_pkg.sv
rtl/rsd_in_if.sv
rtl/rsd_out_if.sv
rtl/rsd_front.sv
rtl/rsd_sqrt_cell.sv
rtl/rsd_div_cell.sv
rtl/ray_segment_distance.sv
bench/rsd_tb_pkg.sv
bench/tb_ray_segment_distance.sv
